// File: sv/key_binding_mask_table_assert.svh
// assertion macros for the key binding mask table checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef KEY_BINDING_MASK_TABLE_ASSERT_SVH
`define KEY_BINDING_MASK_TABLE_ASSERT_SVH

// same-cycle implication
`define KBMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KBMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kbmt_pkg.sv
// package for the key binding mask table: sizes, codes, default bindings
// no dependencies
package kbmt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 16;
    localparam int MASK_W        = 32;
    localparam int DEFAULT_COUNT = 7;
    localparam int DFLT_W        = $clog2(DEFAULT_COUNT);

    typedef enum logic [1:0] {
        FUNC_BIND    = 2'd0,
        FUNC_PRESS   = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_AND     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_cam_res;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
    } t_cam_wr;

    function automatic logic [KEY_W-1:0] default_key(input logic [DFLT_W-1:0] sel);
        logic [KEY_W-1:0] k;
        case (sel)
            DFLT_W'(0): k = KEY_W'(273);
            DFLT_W'(1): k = KEY_W'(274);
            DFLT_W'(2): k = KEY_W'(276);
            DFLT_W'(3): k = KEY_W'(275);
            DFLT_W'(4): k = KEY_W'(13);
            DFLT_W'(5): k = KEY_W'(27);
            DFLT_W'(6): k = KEY_W'(9);
            default:    k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [MASK_W-1:0] default_bits(input logic [DFLT_W-1:0] sel);
        logic [MASK_W-1:0] b;
        case (sel)
            DFLT_W'(0): b = MASK_W'(32'h01);
            DFLT_W'(1): b = MASK_W'(32'h02);
            DFLT_W'(2): b = MASK_W'(32'h04);
            DFLT_W'(3): b = MASK_W'(32'h08);
            DFLT_W'(4): b = MASK_W'(32'h10);
            DFLT_W'(5): b = MASK_W'(32'h20);
            DFLT_W'(6): b = MASK_W'(32'h40);
            default:    b = '0;
        endcase
        return b;
    endfunction

endpackage

// File: sv/kbmt_ifs.sv
// handshake interfaces for the key binding mask table input and result words
// no dependencies
interface kbmt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] key_code;
    logic [31:0]        bind_bits;
    logic [31:0]        keep_mask;

    modport source (output valid, func, key_code, bind_bits, keep_mask, input ready);
    modport sink   (input valid, func, key_code, bind_bits, keep_mask, output ready);
endinterface

interface kbmt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] held_mask;
    logic        matched;
    logic        bind_dropped;

    modport source (output valid, held_mask, matched, bind_dropped, input ready);
    modport sink   (input valid, held_mask, matched, bind_dropped, output ready);
endinterface

// File: sv/kbmt_key_cam.sv
// key register file with parallel compare and first-match priority pick
// depends on kbmt_pkg
module kbmt_key_cam (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kbmt_pkg::t_cam_wr           i_wr,
    input  logic [kbmt_pkg::KEY_W-1:0]  i_key,
    input  logic [kbmt_pkg::CNT_W-1:0]  i_count,
    output kbmt_pkg::t_cam_res          o_res
);

    logic [kbmt_pkg::KEY_W-1:0]         r_keys [kbmt_pkg::TABLE_ENTRIES];
    logic [kbmt_pkg::TABLE_ENTRIES-1:0] hit_vec;
    logic [kbmt_pkg::IDX_W-1:0]         pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kbmt_pkg::DEFAULT_COUNT; i++) begin
                r_keys[i] <= kbmt_pkg::default_key(kbmt_pkg::DFLT_W'(i));
            end
        end else if (i_wr.we) begin
            r_keys[i_wr.addr] <= i_wr.key;
        end
    end

    always_comb begin
        for (int i = 0; i < kbmt_pkg::TABLE_ENTRIES; i++) begin
            hit_vec[i] = (r_keys[i] == i_key) && (kbmt_pkg::CNT_W'(i) < i_count);
        end
    end

    // lowest index wins
    always_comb begin
        pick = '0;
        for (int i = kbmt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                pick = kbmt_pkg::IDX_W'(i);
            end
        end
    end

    assign o_res.hit = |hit_vec;
    assign o_res.idx = pick;

endmodule

// File: sv/key_binding_mask_table.sv
// key binding mask table: a word is searched, then its mask memory update and result word
// commit once the output register is free; a new word is taken only in idle or at commit
// a finished result may wait in the output register while the next word is searched
// reset (synchronous, active low) restores the seven default bindings, count 7, held mask 0;
// no clearing pass, the block is ready in the first cycle after reset
module key_binding_mask_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbmt_in_if.sink    i_in,
    kbmt_out_if.source o_out
);

    kbmt_pkg::t_state                r_state;
    kbmt_pkg::t_state                n_state;
    kbmt_pkg::t_func                 r_func;
    logic [kbmt_pkg::KEY_W-1:0]      r_key;
    logic [kbmt_pkg::MASK_W-1:0]     r_bind;
    logic [kbmt_pkg::MASK_W-1:0]     r_keep;
    logic [kbmt_pkg::CNT_W-1:0]      r_count;
    logic [kbmt_pkg::CNT_W-1:0]      n_count;
    logic [kbmt_pkg::MASK_W-1:0]     r_held;
    logic [kbmt_pkg::MASK_W-1:0]     n_held;
    logic [kbmt_pkg::DEFAULT_COUNT-1:0] r_dflt_wr;
    logic                            r_hit;
    logic [kbmt_pkg::IDX_W-1:0]      r_idx;
    logic [kbmt_pkg::MASK_W-1:0]     r_bits_mem [kbmt_pkg::TABLE_ENTRIES];
    logic [kbmt_pkg::MASK_W-1:0]     r_mem_q;
    logic                            r_out_valid;
    logic [kbmt_pkg::MASK_W-1:0]     r_out_held;
    logic                            r_out_matched;
    logic                            r_out_dropped;
    logic                            n_matched;
    logic                            n_dropped;

    logic                            out_free;
    logic                            in_ready;
    logic                            in_take;
    logic                            commit;
    logic                            dflt_sel;
    logic [kbmt_pkg::MASK_W-1:0]     rd_bits;
    logic                            upd_mem_we;
    logic                            upd_key_we;
    logic                            mem_we;
    logic [kbmt_pkg::IDX_W-1:0]      mem_wa;
    kbmt_pkg::t_cam_wr               cam_wr;
    kbmt_pkg::t_cam_res              cam_res;

    kbmt_key_cam u_key_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cam_wr),
        .i_key   (r_key),
        .i_count (r_count),
        .o_res   (cam_res)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign commit   = (r_state == kbmt_pkg::ST_UPD) && out_free;
    assign in_take  = i_in.valid && in_ready && i_rst_n;

    // untouched default entries read their reset mask
    assign dflt_sel = (r_idx < kbmt_pkg::IDX_W'(kbmt_pkg::DEFAULT_COUNT))
                      && !r_dflt_wr[r_idx[kbmt_pkg::DFLT_W-1:0]];
    assign rd_bits  = dflt_sel ? kbmt_pkg::default_bits(r_idx[kbmt_pkg::DFLT_W-1:0])
                               : r_mem_q;

    always_comb begin
        n_held     = r_held;
        n_count    = r_count;
        n_matched  = r_hit;
        n_dropped  = 1'b0;
        upd_mem_we = 1'b0;
        upd_key_we = 1'b0;
        mem_wa     = r_idx;
        case (r_func)
            kbmt_pkg::FUNC_BIND: begin
                if (r_hit) begin
                    upd_mem_we = 1'b1;
                end else if (r_count < kbmt_pkg::CNT_W'(kbmt_pkg::TABLE_ENTRIES)) begin
                    upd_mem_we = 1'b1;
                    upd_key_we = 1'b1;
                    mem_wa     = r_count[kbmt_pkg::IDX_W-1:0];
                    n_count    = r_count + kbmt_pkg::CNT_W'(1);
                end else begin
                    n_dropped = 1'b1;
                end
            end
            kbmt_pkg::FUNC_PRESS: begin
                if (r_hit) begin
                    n_held = r_held | rd_bits;
                end
            end
            kbmt_pkg::FUNC_RELEASE: begin
                if (r_hit) begin
                    n_held = r_held & ~rd_bits;
                end
            end
            kbmt_pkg::FUNC_AND: begin
                n_held    = r_held & r_keep;
                n_matched = 1'b0;
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    assign mem_we      = commit && upd_mem_we;
    assign cam_wr.we   = commit && upd_key_we;
    assign cam_wr.addr = mem_wa;
    assign cam_wr.key  = r_key;

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        case (r_state)
            kbmt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = kbmt_pkg::ST_SRCH;
                end
            end
            kbmt_pkg::ST_SRCH: begin
                n_state = kbmt_pkg::ST_UPD;
            end
            kbmt_pkg::ST_UPD: begin
                in_ready = out_free;
                if (out_free) begin
                    n_state = i_in.valid ? kbmt_pkg::ST_SRCH : kbmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kbmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbmt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= kbmt_pkg::CNT_W'(kbmt_pkg::DEFAULT_COUNT);
            r_held      <= '0;
            r_dflt_wr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_count <= n_count;
                r_held  <= n_held;
            end
            if (mem_we && (mem_wa < kbmt_pkg::IDX_W'(kbmt_pkg::DEFAULT_COUNT))) begin
                r_dflt_wr[mem_wa[kbmt_pkg::DFLT_W-1:0]] <= 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= kbmt_pkg::t_func'(i_in.func);
            r_key  <= i_in.key_code;
            r_bind <= i_in.bind_bits;
            r_keep <= i_in.keep_mask;
        end
        if (r_state == kbmt_pkg::ST_SRCH) begin
            r_hit <= cam_res.hit;
            r_idx <= cam_res.idx;
        end
        if (commit) begin
            r_out_held    <= n_held;
            r_out_matched <= n_matched;
            r_out_dropped <= n_dropped;
        end
    end

    // mask memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bits_mem[mem_wa] <= r_bind;
        end
        if (r_state == kbmt_pkg::ST_SRCH) begin
            r_mem_q <= r_bits_mem[cam_res.idx];
        end
    end

    assign i_in.ready         = in_ready && i_rst_n;
    assign o_out.valid        = r_out_valid;
    assign o_out.held_mask    = r_out_held;
    assign o_out.matched      = r_out_matched;
    assign o_out.bind_dropped = r_out_dropped;

endmodule

// File: sv/kbmt_checker.sv
// port-level checker for the key binding mask table, bound to the top level
// depends on key_binding_mask_table_assert.svh and key_binding_mask_table
`include "key_binding_mask_table_assert.svh"

module kbmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_held_mask,
    input logic        i_out_matched,
    input logic        i_out_dropped
);

    `KBMT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_held_mask) && $stable(i_out_matched) && $stable(i_out_dropped), "result word changed while stalled")

    `KBMT_ASSERT_IMP(a_drop_no_match, i_out_valid && i_out_dropped, !i_out_matched, "dropped bind reported a match")

    `KBMT_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready, "input taken during search cycle")

endmodule

bind key_binding_mask_table kbmt_checker u_kbmt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_held_mask (o_out.held_mask),
    .i_out_matched   (o_out.matched),
    .i_out_dropped   (o_out.bind_dropped)
);
